### rtl/core/nkd_pkg.sv
// Package: shared types, codes and header classification for the NAL keyframe detector.
`timescale 1ns / 1ps

package nkd_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic is_keyframe;
		logic framing;
	} out_item_t;

	typedef enum logic [1:0] {
		PM_OPEN  = 2'd0,
		PM_THREE = 2'd1,
		PM_FAIL  = 2'd2,
		PM_YES   = 2'd3
	} prefix_t;

	typedef enum logic [1:0] {
		PH_LEN  = 2'd0,
		PH_BODY = 2'd1,
		PH_STOP = 2'd2
	} phase_t;

	localparam logic       CODEC_H264 = 1'b0;
	localparam logic       CODEC_H265 = 1'b1;
	localparam logic       REG_CODEC_MODE = 1'b0;
	localparam logic [2:0] POS_SAT = 3'd4;
	localparam logic [1:0] ZRUN_SAT = 2'd2;
	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE = 8'h01;
	localparam logic [4:0] H264_IDR = 5'd5;
	localparam logic [4:0] H264_SPS = 5'd7;
	localparam logic [5:0] H265_IRAP_LO = 6'd16;
	localparam logic [5:0] H265_IRAP_HI = 6'd21;
	localparam logic [5:0] H265_VPS = 6'd32;
	localparam logic [5:0] H265_SPS = 6'd33;

	function automatic logic is_key_header(input logic [7:0] b, input logic mode);
		logic [5:0] t265;
		logic [4:0] t264;
		t265 = b[6:1];
		t264 = b[4:0];
		if (mode == CODEC_H265) begin
			return ((t265 >= H265_IRAP_LO) && (t265 <= H265_IRAP_HI)) ||
				(t265 == H265_VPS) || (t265 == H265_SPS);
		end
		return (t264 == H264_IDR) || (t264 == H264_SPS);
	endfunction

endpackage

### rtl/core/nkd_cfg.sv
// Module: APB-style configuration register holding the codec mode.
`timescale 1ns / 1ps

module nkd_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic        codec_mode
);

	logic codec_mode_q;
	logic hit;

	assign hit = (paddr[2] == nkd_pkg::REG_CODEC_MODE) && (paddr[1:0] == 2'd0);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_mode_q <= nkd_pkg::CODEC_H264;
		end else if (psel && penable && pwrite && hit) begin
			codec_mode_q <= pwdata[0];
		end
	end

	assign prdata = hit ? {31'd0, codec_mode_q} : 32'd0;
	assign codec_mode = codec_mode_q;

endmodule

### rtl/core/nkd_scan.sv
// Module: per-byte scanner state for start-code and length-prefixed framing.
`timescale 1ns / 1ps

module nkd_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  nkd_pkg::in_item_t     item,
	input  logic                  codec_mode,
	output nkd_pkg::out_item_t    result
);

	logic [2:0]       pos_q, pos_d;
	nkd_pkg::prefix_t pm_q, pm_d;
	logic [1:0]       zrun_q, zrun_d;
	logic             hdr_next_q, hdr_next_d;
	logic             sc_key_q, sc_key_d;
	nkd_pkg::phase_t  phase_q, phase_d;
	logic [1:0]       lcnt_q, lcnt_d;
	logic [31:0]      accum_q, accum_d;
	logic [31:0]      remain_q, remain_d;
	logic             pend_q, pend_d;
	logic             len_key_q, len_key_d;

	logic [7:0]  b;
	logic        key;
	logic [31:0] shifted;
	logic [31:0] remain_dec;
	logic        pend_body;

	always_comb begin
		b = item.data_byte;
		key = nkd_pkg::is_key_header(b, codec_mode);
		shifted = {accum_q[23:0], b};
		remain_dec = remain_q - 32'd1;
		pend_body = pend_q || ((remain_q == accum_q) && key);

		pos_d = (pos_q < nkd_pkg::POS_SAT) ? pos_q + 3'd1 : pos_q;
		pm_d = pm_q;
		case (pos_q)
			3'd0, 3'd1: begin
				if (b != nkd_pkg::BYTE_ZERO) pm_d = nkd_pkg::PM_FAIL;
			end
			3'd2: begin
				if (pm_q == nkd_pkg::PM_OPEN) begin
					if (b == nkd_pkg::BYTE_ONE) pm_d = nkd_pkg::PM_THREE;
					else if (b != nkd_pkg::BYTE_ZERO) pm_d = nkd_pkg::PM_FAIL;
				end
			end
			3'd3: begin
				if (pm_q == nkd_pkg::PM_THREE) pm_d = nkd_pkg::PM_YES;
				else if (pm_q == nkd_pkg::PM_OPEN)
					pm_d = (b == nkd_pkg::BYTE_ONE) ? nkd_pkg::PM_YES : nkd_pkg::PM_FAIL;
			end
			default: begin
				pm_d = pm_q;
			end
		endcase

		sc_key_d = sc_key_q || (hdr_next_q && key);
		hdr_next_d = 1'b0;
		if (b == nkd_pkg::BYTE_ZERO) begin
			zrun_d = (zrun_q < nkd_pkg::ZRUN_SAT) ? zrun_q + 2'd1 : zrun_q;
		end else begin
			hdr_next_d = (b == nkd_pkg::BYTE_ONE) && (zrun_q >= nkd_pkg::ZRUN_SAT);
			zrun_d = 2'd0;
		end

		phase_d = phase_q;
		lcnt_d = lcnt_q;
		accum_d = accum_q;
		remain_d = remain_q;
		pend_d = pend_q;
		len_key_d = len_key_q;
		case (phase_q)
			nkd_pkg::PH_LEN: begin
				accum_d = shifted;
				if (lcnt_q == 2'd3) begin
					lcnt_d = 2'd0;
					if (shifted == 32'd0) begin
						phase_d = nkd_pkg::PH_STOP;
					end else begin
						remain_d = shifted;
						pend_d = 1'b0;
						phase_d = nkd_pkg::PH_BODY;
					end
				end else begin
					lcnt_d = lcnt_q + 2'd1;
				end
			end
			nkd_pkg::PH_BODY: begin
				remain_d = remain_dec;
				pend_d = pend_body;
				if (remain_dec == 32'd0) begin
					len_key_d = len_key_q || pend_body;
					pend_d = 1'b0;
					accum_d = 32'd0;
					phase_d = nkd_pkg::PH_LEN;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase

		result.framing = (pm_d != nkd_pkg::PM_YES);
		result.is_keyframe = (pm_d == nkd_pkg::PM_YES) ? sc_key_d : len_key_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 3'd0;
			pm_q <= nkd_pkg::PM_OPEN;
			zrun_q <= 2'd0;
			hdr_next_q <= 1'b0;
			sc_key_q <= 1'b0;
			phase_q <= nkd_pkg::PH_LEN;
			lcnt_q <= 2'd0;
			accum_q <= 32'd0;
			remain_q <= 32'd0;
			pend_q <= 1'b0;
			len_key_q <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				pos_q <= 3'd0;
				pm_q <= nkd_pkg::PM_OPEN;
				zrun_q <= 2'd0;
				hdr_next_q <= 1'b0;
				sc_key_q <= 1'b0;
				phase_q <= nkd_pkg::PH_LEN;
				lcnt_q <= 2'd0;
				accum_q <= 32'd0;
				remain_q <= 32'd0;
				pend_q <= 1'b0;
				len_key_q <= 1'b0;
			end else begin
				pos_q <= pos_d;
				pm_q <= pm_d;
				zrun_q <= zrun_d;
				hdr_next_q <= hdr_next_d;
				sc_key_q <= sc_key_d;
				phase_q <= phase_d;
				lcnt_q <= lcnt_d;
				accum_q <= accum_d;
				remain_q <= remain_d;
				pend_q <= pend_d;
				len_key_q <= len_key_d;
			end
		end
	end

endmodule

### rtl/core/nal_keyframe_detector.sv
// Top level: NAL keyframe detector with input register, byte scanner and result register.
//
//   channel | direction | handshake            | payload
//   src     | in        | src_valid/src_stall  | src_data  (data_byte, last_byte)
//   dst     | out       | dst_valid/dst_stall  | dst_data  (is_keyframe, framing)
//   cfg     | in        | psel/penable/pwrite  | paddr, pwdata, prdata
//
// One byte per cycle sustained while the input is not stalled; a byte is scanned from the input register.
// A result is presented from the result register once the packet's last byte has been scanned.
// The input register holds only a last byte that meets a stalled, waiting result.
// Reset clears the scanner, the codec mode and both valid flags.
`timescale 1ns / 1ps

module nal_keyframe_detector (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  nkd_pkg::in_item_t   src_data,
	output logic                dst_valid,
	input  logic                dst_stall,
	output nkd_pkg::out_item_t  dst_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic               valid_s1;
	nkd_pkg::in_item_t  item_s1;
	logic               advance;
	logic               codec_mode;
	nkd_pkg::out_item_t result;
	logic               res_valid_q;
	nkd_pkg::out_item_t res_q;

	nkd_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.codec_mode (codec_mode)
	);

	nkd_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.codec_mode (codec_mode),
		.result     (result)
	);

	assign advance = valid_s1 && (!item_s1.last_byte || !res_valid_q || !dst_stall);
	assign src_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) item_s1 <= src_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) res_q <= result;
	end

	assign dst_valid = res_valid_q;
	assign dst_data = res_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> valid_s1 && item_s1.last_byte && res_valid_q)
		else $error("input stalled without a blocked last byte");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.last_byte) |=> dst_valid)
		else $error("last byte scanned but no result presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(dst_valid && dst_stall) |-> !(advance && item_s1.last_byte))
		else $error("pending result overwritten");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dst_valid) |-> $past(advance && item_s1.last_byte))
		else $error("result appeared without a scanned last byte");

endmodule

### sim/tb_nal_keyframe_detector.sv
// Testbench: directed and random packets checked against a byte-level keyframe predictor.
`timescale 1ns / 1ps

module tb_nal_keyframe_detector;

	localparam logic [2:0] CODEC_ADDR = 3'd4 * 3'(nkd_pkg::REG_CODEC_MODE);

	typedef struct packed {
		logic               mode;
		logic [3:0]         count;
		logic [63:0]        bytes;
		logic               typed;
		nkd_pkg::out_item_t want;
	} packet_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               src_valid = 1'b0;
	logic               src_stall;
	nkd_pkg::in_item_t  src_data = '0;
	logic               dst_valid;
	logic               dst_stall = 1'b0;
	nkd_pkg::out_item_t dst_data;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	nal_keyframe_detector dut (.*);

	always #2 clk = ~clk;

	int errors = 0;
	int bytes_sent = 0;
	int src_gap_pct = 0;
	int dst_gap_pct = 0;
	int hold_asks = 0;
	int hold_served = 0;
	int hold_left = 0;
	nkd_pkg::out_item_t verdicts [$];
	logic [7:0] pkt [$];
	packet_row_t dir_rows [7];

	// predictor state
	logic             cfg_mode;
	logic [2:0]       pos;
	nkd_pkg::prefix_t prefix_st;
	logic [1:0]       zeros;
	logic             hdr_next;
	logic             sc_key;
	nkd_pkg::phase_t  len_ph;
	logic [1:0]       len_cnt;
	logic [31:0]      len_acc;
	logic [31:0]      body_left;
	logic             pend_key;
	logic             len_key;

	task automatic report(input string msg);
		errors++;
		$display("%0t: %s", $time, msg);
	endtask

	function automatic void add_byte(input logic [7:0] b);
		pkt.insert(pkt.size(), b);
	endfunction

	function automatic logic key_header(input logic [7:0] b);
		logic [5:0] t6;
		logic [4:0] t5;
		t6 = b[6:1];
		t5 = b[4:0];
		if (cfg_mode == nkd_pkg::CODEC_H265) begin
			return (t6 >= nkd_pkg::H265_IRAP_LO && t6 <= nkd_pkg::H265_IRAP_HI) ||
				t6 == nkd_pkg::H265_VPS || t6 == nkd_pkg::H265_SPS;
		end
		return t5 == nkd_pkg::H264_IDR || t5 == nkd_pkg::H264_SPS;
	endfunction

	function automatic void clear_scan();
		pos = '0;
		prefix_st = nkd_pkg::PM_OPEN;
		zeros = '0;
		hdr_next = 1'b0;
		sc_key = 1'b0;
		len_ph = nkd_pkg::PH_LEN;
		len_cnt = '0;
		len_acc = '0;
		body_left = '0;
		pend_key = 1'b0;
		len_key = 1'b0;
	endfunction

	function automatic logic scan_byte(input logic [7:0] b, input logic last,
			output nkd_pkg::out_item_t v);
		logic was_hdr;
		v = '0;
		case (pos)
			3'd0, 3'd1: begin
				if (b != nkd_pkg::BYTE_ZERO) prefix_st = nkd_pkg::PM_FAIL;
			end
			3'd2: begin
				if (prefix_st == nkd_pkg::PM_OPEN) begin
					if (b == nkd_pkg::BYTE_ONE) prefix_st = nkd_pkg::PM_THREE;
					else if (b != nkd_pkg::BYTE_ZERO) prefix_st = nkd_pkg::PM_FAIL;
				end
			end
			3'd3: begin
				if (prefix_st == nkd_pkg::PM_THREE) prefix_st = nkd_pkg::PM_YES;
				else if (prefix_st == nkd_pkg::PM_OPEN) begin
					if (b == nkd_pkg::BYTE_ONE) prefix_st = nkd_pkg::PM_YES;
					else prefix_st = nkd_pkg::PM_FAIL;
				end
			end
			default: ;
		endcase
		if (pos < nkd_pkg::POS_SAT) pos++;

		was_hdr = hdr_next;
		hdr_next = 1'b0;
		if (was_hdr && key_header(b)) sc_key = 1'b1;
		if (b == nkd_pkg::BYTE_ZERO) begin
			if (zeros < nkd_pkg::ZRUN_SAT) zeros++;
		end else begin
			if (b == nkd_pkg::BYTE_ONE && zeros >= nkd_pkg::ZRUN_SAT) hdr_next = 1'b1;
			zeros = '0;
		end

		if (len_ph == nkd_pkg::PH_LEN) begin
			len_acc = {len_acc[23:0], b};
			if (len_cnt == 2'd3) begin
				len_cnt = '0;
				if (len_acc == '0) len_ph = nkd_pkg::PH_STOP;
				else begin
					body_left = len_acc;
					pend_key = 1'b0;
					len_ph = nkd_pkg::PH_BODY;
				end
			end else begin
				len_cnt++;
			end
		end else if (len_ph == nkd_pkg::PH_BODY) begin
			if (body_left == len_acc && key_header(b)) pend_key = 1'b1;
			body_left--;
			if (body_left == '0) begin
				if (pend_key) len_key = 1'b1;
				pend_key = 1'b0;
				len_acc = '0;
				len_ph = nkd_pkg::PH_LEN;
			end
		end

		if (!last) return 1'b0;
		if (prefix_st == nkd_pkg::PM_YES) v = '{sc_key, 1'b0};
		else v = '{len_key, 1'b1};
		clear_scan();
		return 1'b1;
	endfunction

	always @(negedge clk) begin
		nkd_pkg::out_item_t want;
		if (arst_n && dst_valid && !dst_stall) begin
			if (verdicts.size() == 0) begin
				report($sformatf("result with nothing expected: keyframe=%b framing=%b",
					dst_data.is_keyframe, dst_data.framing));
			end else begin
				want = verdicts.pop_front();
				if (dst_data.is_keyframe !== want.is_keyframe)
					report($sformatf("is_keyframe %b, expected %b",
						dst_data.is_keyframe, want.is_keyframe));
				if (dst_data.framing !== want.framing)
					report($sformatf("framing %b, expected %b", dst_data.framing, want.framing));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_asks != hold_served) begin
			hold_served = hold_asks;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			dst_stall <= 1'b1;
		end else begin
			dst_stall <= ($urandom_range(99) < dst_gap_pct);
		end
	end

	task automatic push_byte(input logic [7:0] b, input logic last, input logic fixed,
			input nkd_pkg::out_item_t fixed_v);
		nkd_pkg::out_item_t v;
		while ($urandom_range(99) < src_gap_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_data <= '{b, last};
		do @(negedge clk); while (src_stall);
		if (scan_byte(b, last, v)) verdicts.insert(verdicts.size(), fixed ? fixed_v : v);
		@(posedge clk);
	endtask

	task automatic send_packet();
		foreach (pkt[k]) push_byte(pkt[k], k == pkt.size() - 1, 1'b0, '0);
		bytes_sent += pkt.size();
	endtask

	task automatic settle();
		src_valid <= 1'b0;
		while (verdicts.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= CODEC_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		rdata = prdata;
		@(posedge clk);
	endtask

	task automatic set_codec(input logic m);
		logic [31:0] rd;
		apb_access(1'b1, {31'b0, m}, rd);
		apb_access(1'b0, '0, rd);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (rd !== {31'b0, m}) report($sformatf("codec_mode reads %h, expected %0b", rd, m));
		cfg_mode = m;
	endtask

	function automatic logic [7:0] filler();
		case ($urandom_range(3))
			0: return nkd_pkg::BYTE_ZERO;
			1: return nkd_pkg::BYTE_ONE;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] nal_header();
		logic [5:0] t6;
		if ($urandom_range(1)) return 8'($urandom);
		if (cfg_mode == nkd_pkg::CODEC_H265) begin
			case ($urandom_range(2))
				0: t6 = nkd_pkg::H265_VPS;
				1: t6 = nkd_pkg::H265_SPS;
				default: t6 = 6'($urandom_range(21, 16));
			endcase
			return {1'($urandom), t6, 1'($urandom)};
		end
		return {3'($urandom), ($urandom_range(1) ? nkd_pkg::H264_IDR : nkd_pkg::H264_SPS)};
	endfunction

	task automatic build_packet();
		int kind;
		int pick;
		int nals;
		int keep;
		logic [31:0] size;
		pkt.delete();
		kind = $urandom_range(9);
		nals = $urandom_range(3, 1);
		if (kind < 4) begin
			repeat (nals) begin
				if ($urandom_range(1)) add_byte(nkd_pkg::BYTE_ZERO);
				add_byte(nkd_pkg::BYTE_ZERO);
				add_byte(nkd_pkg::BYTE_ZERO);
				add_byte(nkd_pkg::BYTE_ONE);
				add_byte(nal_header());
				repeat ($urandom_range(6)) add_byte(filler());
			end
		end else if (kind < 8) begin
			for (int n = 0; n < nals; n++) begin
				pick = $urandom_range(9);
				case (pick)
					0: size = '0;
					1: size = $urandom;
					2: size = $urandom_range(300, 9);
					default: size = $urandom_range(8, 1);
				endcase
				for (int k = 3; k >= 0; k--) add_byte(size[8*k +: 8]);
				if (pick == 0) begin
					repeat ($urandom_range(4)) add_byte(filler());
					break;
				end
				if (pick == 1) keep = $urandom_range(6);
				else if (pick == 3) keep = $urandom_range(size - 1, 0);
				else keep = size;
				if (keep > 0) begin
					add_byte(nal_header());
					repeat (keep - 1) add_byte(filler());
				end
				if (pick == 1 || pick == 3) break;
			end
			if ($urandom_range(4) == 0) repeat ($urandom_range(3, 1)) add_byte(filler());
		end else if (kind == 8) begin
			repeat ($urandom_range(12, 1)) add_byte(8'($urandom));
		end else begin
			repeat ($urandom_range(3, 1)) add_byte(filler());
		end
	endtask

	task automatic run_phase(input logic m, input int src_pct, input int dst_pct,
			input int budget);
		int start;
		settle();
		set_codec(m);
		src_gap_pct = src_pct;
		dst_gap_pct = dst_pct;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			build_packet();
			send_packet();
		end
	endtask

	initial begin
		#2_000_000;
		$display("tb_nal_keyframe_detector failed");
		$finish;
	end

	initial begin
		clear_scan();
		cfg_mode = nkd_pkg::CODEC_H264;
		dir_rows[0] = '{nkd_pkg::CODEC_H264, 4'd7, 64'h0000_0100_0001_6500, 1'b1,
			'{1'b1, 1'b0}};
		dir_rows[1] = '{nkd_pkg::CODEC_H264, 4'd1, 64'hFF00_0000_0000_0000, 1'b1,
			'{1'b0, 1'b1}};
		dir_rows[2] = '{nkd_pkg::CODEC_H264, 4'd4, 64'h0000_0000_0000_0000, 1'b1,
			'{1'b0, 1'b1}};
		dir_rows[3] = '{nkd_pkg::CODEC_H264, 4'd7, 64'h0000_0002_6500_0000, 1'b1,
			'{1'b1, 1'b1}};
		dir_rows[4] = '{nkd_pkg::CODEC_H264, 4'd5, 64'h0000_0005_6500_0000, 1'b1,
			'{1'b0, 1'b1}};
		dir_rows[5] = '{nkd_pkg::CODEC_H265, 4'd4, 64'h0000_0140_0000_0000, 1'b1,
			'{1'b1, 1'b0}};
		dir_rows[6] = '{nkd_pkg::CODEC_H265, 4'd7, 64'h0000_0003_2A01_FF00, 1'b0,
			'{1'b0, 1'b0}};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			if (r == 0 || dir_rows[r].mode != cfg_mode) begin
				settle();
				set_codec(dir_rows[r].mode);
			end
			for (int k = 0; k < dir_rows[r].count; k++)
				push_byte(dir_rows[r].bytes[63 - 8*k -: 8], k == dir_rows[r].count - 1,
					dir_rows[r].typed, dir_rows[r].want);
		end

		run_phase(nkd_pkg::CODEC_H265, 36, 76, 440);
		run_phase(nkd_pkg::CODEC_H264, 76, 36, 440);
		run_phase(nkd_pkg::CODEC_H265, 0, 0, 440);

		// hold the receiver off while single-byte packets pile up
		settle();
		hold_asks++;
		repeat (60) begin
			pkt.delete();
			add_byte(8'($urandom));
			send_packet();
		end

		run_phase(nkd_pkg::CODEC_H264, 20, 20, 380);
		settle();
		if (errors == 0) $display("tb_nal_keyframe_detector passed");
		else $display("tb_nal_keyframe_detector failed");
		$finish;
	end

endmodule
